### src/selective_repeat_receiver_top_macros.svh
// ----------------------------------------------------------------------------
// Selective repeat receiver assertion macros
// Concurrent checks used at the end of the receiver top level.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SRR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRR_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/srr_pkg.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver package
// Window sizing, widths, result codes and the control state type.
// ----------------------------------------------------------------------------
package srr_pkg;

	localparam int WINDOW    = 8;
	localparam int SEQ_SPACE = 16;

	localparam int SEQ_W  = $clog2(SEQ_SPACE);
	localparam int IDX_W  = $clog2(WINDOW);
	localparam int PAY_W  = 160;

	localparam int PAY_BYTES     = 20;
	localparam int ZERO_CHAR     = 48;
	localparam int ACK_CSUM_BASE = PAY_BYTES * ZERO_CHAR;
	localparam int BSUM_W        = $clog2(PAY_BYTES * 255 + 1);
	localparam int PSUM_W        = $clog2(8 * 255 + 1);

	localparam logic RES_DELIVER = 1'b0;
	localparam logic RES_ACK     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DECIDE,
		ST_READ,
		ST_DELIVER,
		ST_ACK
	} srr_state_t;

	// unsigned sum of the eight bytes of a word
	function automatic logic [PSUM_W-1:0] byte_sum8(input logic [63:0] w);
		logic [PSUM_W-1:0] s;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + PSUM_W'(w[8*i +: 8]);
		end
		return s;
	endfunction

endpackage

### src/selective_repeat_receiver_top.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver
// Checks each data packet, stores a good, new, in-window one in the slot store,
// delivers in-order payloads and closes every packet with one ACK word.
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | words per packet
//  in      | input     | in_valid/in_stall | 1
//  out     | output    | out_valid/out_stall | 0..WINDOW deliveries + 1 ACK
//
//  A packet that stores nothing passes the idle, sum, decide and ACK states; a
//  stored packet also passes a read state, and each delivered payload takes one
//  slot store read and one output load, plus any output stall.
//  The slot store is one 160-bit synchronous RAM, one read or write a cycle.
//  Reset clears the window base, the received flags and sets the ACK bit.
//  A stalled output holds its word; the next packet is taken while the ACK waits.

`include "selective_repeat_receiver_top_macros.svh"

module selective_repeat_receiver_top
	import srr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         seq_number,
	input  logic signed [4:0]  ack_field,
	input  logic signed [31:0] packet_checksum,
	input  logic [63:0]        payload_low,
	input  logic [63:0]        payload_mid,
	input  logic [31:0]        payload_high,

	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [63:0]        out_payload_low,
	output logic [63:0]        out_payload_mid,
	output logic [31:0]        out_payload_high,
	output logic [3:0]         ack_number,
	output logic               ack_seq_bit,
	output logic [9:0]         ack_checksum,
	output logic               last_result
);

	srr_state_t state_q, state_d;

	// packet registers
	logic [3:0]        seq_q;
	logic [4:0]        ack_q;
	logic [31:0]       ck_q;
	logic [PAY_W-1:0]  pay_q;
	logic [PSUM_W-1:0] psum_lo_q, psum_mid_q, psum_hi_q;

	logic [SEQ_W-1:0]  base_q;
	logic              ack_bit_q;
	logic [WINDOW-1:0] recv_q;
	logic [SEQ_W-1:0]  acknum_q;

	logic [PAY_W-1:0]  slot_mem [WINDOW];
	logic [PAY_W-1:0]  rd_data_q;

	logic              out_valid_q;

	// decide-stage logic
	logic [BSUM_W-1:0] byte_total;
	logic [31:0]       sum_total;
	logic              ck_ok;
	logic [SEQ_W-1:0]  seq_mod;
	logic [SEQ_W-1:0]  offset;
	logic [SEQ_W-1:0]  back_dist;
	logic [SEQ_W-1:0]  base_m1;
	logic [IDX_W-1:0]  seq_idx;
	logic [IDX_W-1:0]  base_idx;
	logic              in_win;
	logic              do_store;
	logic [SEQ_W-1:0]  acknum_d;

	logic              accept;
	logic              out_free;
	logic              rd_en;
	logic              load_dlv;
	logic              load_ack;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign byte_total = BSUM_W'(psum_lo_q) + BSUM_W'(psum_mid_q) + BSUM_W'(psum_hi_q);
	assign sum_total  = 32'(byte_total) + 32'(seq_q) + {{27{ack_q[4]}}, ack_q};
	assign ck_ok      = (sum_total == ck_q);

	assign seq_mod   = SEQ_W'(32'(seq_q) % SEQ_SPACE);
	assign offset    = SEQ_W'(seq_mod - base_q);
	assign back_dist = SEQ_W'(base_q - seq_mod - SEQ_W'(1));
	assign base_m1   = SEQ_W'(base_q - SEQ_W'(1));
	assign seq_idx   = IDX_W'(32'(seq_mod) % WINDOW);
	assign base_idx  = IDX_W'(32'(base_q) % WINDOW);
	assign in_win    = (32'(offset) < WINDOW);
	assign do_store  = ck_ok && in_win && !recv_q[seq_idx];

	always_comb begin
		if (!ck_ok) begin
			acknum_d = base_m1;
		end else if (in_win) begin
			acknum_d = seq_mod;
		end else if (32'(back_dist) < WINDOW) begin
			acknum_d = seq_mod;    // duplicate from the previous window
		end else begin
			acknum_d = base_m1;
		end
	end

	// control
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		load_dlv = 1'b0;
		load_ack = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = do_store ? ST_READ : ST_ACK;
			end
			ST_READ: begin
				if (recv_q[base_idx]) begin
					rd_en   = 1'b1;
					state_d = ST_DELIVER;
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_DELIVER: begin
				if (out_free) begin
					load_dlv = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_ACK: begin
				if (out_free) begin
					load_ack = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// packet capture and partial byte sums
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q <= seq_number;
			ack_q <= ack_field;
			ck_q  <= packet_checksum;
			pay_q <= {payload_high, payload_mid, payload_low};
		end
		if (state_q == ST_SUM) begin
			psum_lo_q  <= byte_sum8(pay_q[63:0]);
			psum_mid_q <= byte_sum8(pay_q[127:64]);
			psum_hi_q  <= byte_sum8({32'b0, pay_q[159:128]});
		end
		if (state_q == ST_DECIDE) begin
			acknum_q <= acknum_d;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			ack_bit_q <= 1'b1;
			recv_q    <= '0;
		end else begin
			if (state_q == ST_DECIDE && do_store) begin
				recv_q[seq_idx] <= 1'b1;
			end
			if (load_dlv) begin
				recv_q[base_idx] <= 1'b0;
				base_q           <= SEQ_W'(base_q + SEQ_W'(1));
			end
			if (load_ack) begin
				ack_bit_q <= ~ack_bit_q;
			end
		end
	end

	// slot store: written in the decide cycle, read no earlier than the next one
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && do_store) begin
			slot_mem[seq_idx] <= pay_q;
		end
		if (rd_en) begin
			rd_data_q <= slot_mem[base_idx];
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_dlv || load_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_dlv) begin
			result_kind      <= RES_DELIVER;
			out_payload_low  <= rd_data_q[63:0];
			out_payload_mid  <= rd_data_q[127:64];
			out_payload_high <= rd_data_q[159:128];
			ack_number       <= '0;
			ack_seq_bit      <= 1'b0;
			ack_checksum     <= '0;
			last_result      <= 1'b0;
		end else if (load_ack) begin
			result_kind      <= RES_ACK;
			out_payload_low  <= '0;
			out_payload_mid  <= '0;
			out_payload_high <= '0;
			ack_number       <= 4'(acknum_q);
			ack_seq_bit      <= ack_bit_q;
			ack_checksum     <= 10'(32'(ack_bit_q) + 32'(acknum_q) + ACK_CSUM_BASE);
			last_result      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	`SRR_ASSERT_NOW(a_base_clear_idle, state_q == ST_IDLE, !recv_q[base_idx], "slot at base still held while idle")
	`SRR_ASSERT_NEXT(a_base_advance, load_dlv, base_q == SEQ_W'($past(base_q) + SEQ_W'(1)), "base did not advance on delivery")
	`SRR_ASSERT_NOW(a_last_is_ack, out_valid_q, result_kind == last_result, "last word is not the ACK")

endmodule

### tb/sv/selective_repeat_receiver_top_tb.sv
// ----------------------------------------------------------------------------
// Selective repeat receiver testbench
// Drives checked and corrupted data packets around the receive window and
// follows each accepted packet with a prediction of its delivered payloads
// and closing ACK word; every output word is compared with the oldest one
// still owed. Both channels idle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_top_tb
	import srr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES   = 4 + 2 * WINDOW;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct packed {
		logic        kind;
		logic [63:0] low;
		logic [63:0] mid;
		logic [31:0] high;
		logic [3:0]  ackn;
		logic        seq_bit;
		logic [9:0]  csum;
		logic        last;
	} srr_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [3:0]         seq_number = '0;
	logic signed [4:0]  ack_field = '0;
	logic signed [31:0] packet_checksum = '0;
	logic [63:0]        payload_low = '0;
	logic [63:0]        payload_mid = '0;
	logic [31:0]        payload_high = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               result_kind;
	logic [63:0]        out_payload_low;
	logic [63:0]        out_payload_mid;
	logic [31:0]        out_payload_high;
	logic [3:0]         ack_number;
	logic               ack_seq_bit;
	logic [9:0]         ack_checksum;
	logic               last_result;

	int in_idle_pct  = 0;
	int out_idle_pct = 0;

	// additive packet checksum: seq + signed ack field + twenty unsigned bytes
	function automatic logic signed [31:0] packet_sum(input logic [3:0] seq,
			input logic signed [4:0] ackf, input logic [63:0] lo, input logic [63:0] mid,
			input logic [31:0] hi);
		int s;
		s = int'(seq) + int'(ackf);
		for (int i = 0; i < 8; i++) begin
			s = s + int'(lo[8*i +: 8]) + int'(mid[8*i +: 8]);
		end
		for (int i = 0; i < 4; i++) begin
			s = s + int'(hi[8*i +: 8]);
		end
		return s;
	endfunction

	class arq_tracker;
		logic [SEQ_W-1:0] rx_base;
		logic             ack_toggle;
		logic             held [WINDOW];
		logic [63:0]      held_low [WINDOW];
		logic [63:0]      held_mid [WINDOW];
		logic [31:0]      held_high [WINDOW];
		srr_word_t        owed [$];
		int               errors;

		function new();
			rx_base = '0;
			ack_toggle = 1'b1;
			foreach (held[i]) held[i] = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		// work out the words one accepted packet causes
		function void take_packet(input logic [3:0] seq, input logic signed [4:0] ackf,
				input logic signed [31:0] ck, input logic [63:0] lo, input logic [63:0] mid,
				input logic [31:0] hi);
			logic [SEQ_W-1:0] offset;
			logic [SEQ_W-1:0] back;
			logic [SEQ_W-1:0] ackn;
			logic [IDX_W-1:0] idx;
			logic [IDX_W-1:0] b;
			int               n;
			srr_word_t        w;
			n = 0;
			offset = seq - rx_base;
			back = rx_base - seq - 1'b1;
			if (packet_sum(seq, ackf, lo, mid, hi) != ck) begin
				ackn = rx_base - 1'b1;
			end else if (offset < WINDOW) begin
				idx = seq[IDX_W-1:0];
				if (!held[idx]) begin
					held[idx] = 1'b1;
					held_low[idx] = lo;
					held_mid[idx] = mid;
					held_high[idx] = hi;
					b = rx_base[IDX_W-1:0];
					while (n < WINDOW && held[b]) begin
						w = '0;
						w.kind = RES_DELIVER;
						w.low = held_low[b];
						w.mid = held_mid[b];
						w.high = held_high[b];
						owed.push_back(w);
						held[b] = 1'b0;
						rx_base = rx_base + 1'b1;
						b = rx_base[IDX_W-1:0];
						n++;
					end
				end
				ackn = seq;
			end else if (back < WINDOW) begin
				// duplicate from the previous window: acked again
				ackn = seq;
			end else begin
				ackn = rx_base - 1'b1;
			end
			w = '0;
			w.kind = RES_ACK;
			w.ackn = ackn;
			w.seq_bit = ack_toggle;
			w.csum = 10'(int'(ack_toggle) + int'(ackn) + ACK_CSUM_BASE);
			w.last = 1'b1;
			owed.push_back(w);
			ack_toggle = ~ack_toggle;
		endfunction

		function void cmp_field(input string name, input logic [63:0] exp_v,
				input logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_word(input srr_word_t got);
			srr_word_t w;
			if (owed.size() == 0) begin
				$error("output word with nothing owed: %0h", got);
				errors++;
				return;
			end
			w = owed.pop_front();
			cmp_field("result_kind", w.kind, got.kind);
			cmp_field("out_payload_low", w.low, got.low);
			cmp_field("out_payload_mid", w.mid, got.mid);
			cmp_field("out_payload_high", w.high, got.high);
			cmp_field("ack_number", w.ackn, got.ackn);
			cmp_field("ack_seq_bit", w.seq_bit, got.seq_bit);
			cmp_field("ack_checksum", w.csum, got.csum);
			cmp_field("last_result", w.last, got.last);
		endfunction
	endclass

	arq_tracker tracker;

	selective_repeat_receiver_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.seq_number       (seq_number),
		.ack_field        (ack_field),
		.packet_checksum  (packet_checksum),
		.payload_low      (payload_low),
		.payload_mid      (payload_mid),
		.payload_high     (payload_high),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_kind      (result_kind),
		.out_payload_low  (out_payload_low),
		.out_payload_mid  (out_payload_mid),
		.out_payload_high (out_payload_high),
		.ack_number       (ack_number),
		.ack_seq_bit      (ack_seq_bit),
		.ack_checksum     (ack_checksum),
		.last_result      (last_result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// output side: random stall, check each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < out_idle_pct);
			if (out_valid && !out_stall) begin
				tracker.check_word({result_kind, out_payload_low, out_payload_mid,
					out_payload_high, ack_number, ack_seq_bit, ack_checksum, last_result});
			end
		end
	end

	// ends the run when neither channel moves a word for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("selective_repeat_receiver_top test failed");
		$finish;
	end

	task automatic send_packet(input logic [3:0] seq, input logic signed [4:0] ackf,
			input logic signed [31:0] ck, input logic [63:0] lo, input logic [63:0] mid,
			input logic [31:0] hi);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		seq_number <= seq;
		ack_field <= ackf;
		packet_checksum <= ck;
		payload_low <= lo;
		payload_mid <= mid;
		payload_high <= hi;
		do @(posedge clk); while (in_stall !== 1'b0);
		tracker.take_packet(seq, ackf, ck, lo, mid, hi);
	endtask

	task automatic send_good(input logic [3:0] seq, input logic signed [4:0] ackf,
			input logic [63:0] lo, input logic [63:0] mid, input logic [31:0] hi);
		send_packet(seq, ackf, packet_sum(seq, ackf, lo, mid, hi), lo, mid, hi);
	endtask

	// sender holds off until every owed word is out and the block has settled
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_random();
		logic [3:0]         seq;
		logic signed [4:0]  ackf;
		logic signed [31:0] ck;
		logic [63:0]        lo;
		logic [63:0]        mid;
		logic [31:0]        hi;
		int                 pick;
		lo = {$urandom, $urandom};
		mid = {$urandom, $urandom};
		hi = $urandom;
		ackf = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			// mostly just past the base so the window keeps sliding
			seq = tracker.rx_base + 4'($urandom_range(0, 1) ? $urandom_range(0, 2)
				: $urandom_range(0, WINDOW - 1));
		end else if (pick < 70) begin
			seq = tracker.rx_base - 4'(1 + $urandom_range(0, WINDOW - 1));
		end else begin
			seq = 4'($urandom);
		end
		ck = packet_sum(seq, ackf, lo, mid, hi);
		if (pick >= 88) begin
			ck = $urandom_range(0, 1) ? ck + 32'($urandom_range(1, 300)) : 32'($urandom);
		end
		send_packet(seq, ackf, ck, lo, mid, hi);
	endtask

	initial begin : stimulus
		int          in_pct [3];
		int          out_pct [3];
		int          counts [3];
		logic [63:0] ones64;
		logic [31:0] ones32;
		in_pct = '{38, 87, 0};
		out_pct = '{87, 38, 0};
		counts = '{160, 160, 150};
		ones64 = '1;
		ones32 = '1;
		tracker = new();
		in_idle_pct = in_pct[0];
		out_idle_pct = out_pct[0];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// in order at base zero, zero payload
		send_good(4'd0, -5'sd1, '0, '0, '0);
		// corrupted, checksum at both extremes
		send_packet(4'd3, 5'sd15, 32'sh8000_0000, {$urandom, $urandom}, {$urandom, $urandom},
			$urandom);
		send_packet(4'd3, -5'sd16, 32'sh7fff_ffff, {$urandom, $urandom}, {$urandom, $urandom},
			$urandom);
		// previous window duplicates
		send_good(4'd0, 5'sd0, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		send_good(4'd9, -5'sd1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		// out of order: hold seven, repeat one held, then fill the gap for a full release
		for (int s = 2; s <= 8; s++) begin
			send_good(4'(s), -5'sd1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		end
		send_good(4'd5, 5'sd7, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		send_good(4'd1, -5'sd1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		// all-ones payload held at the top sequence number
		send_good(4'd15, 5'sd15, ones64, ones64, ones32);
		// negative checksum word, in order
		send_good(4'd9, -5'sd16, '0, '0, '0);
		// checksum off by one
		send_packet(4'd10, -5'sd1, packet_sum(4'd10, -5'sd1, ones64, ones64, ones32) + 32'sd1,
			ones64, ones64, ones32);
		send_good(4'd8, 5'sd3, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
		drain_results();

		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct = in_pct[ph];
			out_idle_pct = out_pct[ph];
			for (int i = 0; i < counts[ph]; i++) begin
				if (i == counts[ph] / 2) drain_results();
				send_random();
			end
			drain_results();
		end

		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("selective_repeat_receiver_top test passed");
		end else begin
			$display("selective_repeat_receiver_top test failed");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/srr_pkg.sv
src/selective_repeat_receiver_top.sv
tb/sv/selective_repeat_receiver_top_tb.sv
